FILE: hw/rtl/spq_pkg.sv
// Shared types and codes for the sorted priority queue.
`default_nettype none
package spq_pkg;

  localparam int unsigned DefaultDepth = 16;
  localparam int unsigned PrioW = 16;
  localparam int unsigned DataW = 32;
  localparam int unsigned TotalW = 5;

  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_POP  = 2'd1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY_POP = 2'd1;
  localparam logic [1:0] ST_FULL_PUSH = 2'd2;

  typedef struct packed {
    logic                    push;
    logic                    pop;
    logic signed [PrioW-1:0] prio;
    logic        [DataW-1:0] data;
  } spq_cmd_t;

endpackage
`default_nettype wire

FILE: hw/rtl/sorted_priority_queue.sv
// Top level of the sorted priority queue built from a chain of cells.
// The queue holds up to DEPTH entries in a row of cells kept in service
// order, cell 0 being the head. Every cell compares the pushed priority
// with its own in parallel and then keeps its entry, takes the new one or
// takes its neighbor's. A push or a pop takes effect at the next clock edge,
// and a new item can be accepted in every cycle while the output side
// takes results. Each accepted item produces one result transfer that
// reports the head data, whether the queue is empty, the entry count and
// a status. There is no clearing pass after reset.
`default_nettype none
module sorted_priority_queue #(
  parameter int unsigned DEPTH = spq_pkg::DefaultDepth
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic        [1:0]                in_opcode,
  input  logic signed [spq_pkg::PrioW-1:0] in_new_priority,
  input  logic signed [spq_pkg::DataW-1:0] in_new_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [spq_pkg::DataW-1:0] out_head_data,
  output logic                             out_head_present,
  output logic        [spq_pkg::TotalW-1:0] out_entry_total,
  output logic        [1:0]                out_status
);
  import spq_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned EtW  = (CntW < TotalW) ? CntW : TotalW;

  logic                    accept;
  logic                    full, empty;
  spq_cmd_t                cmd;
  logic [DEPTH-1:0]        stay_v, valid_v;
  logic signed [PrioW-1:0] prio_a [DEPTH];
  logic        [DataW-1:0] data_a [DEPTH];

  logic            out_valid_r, out_valid_nxt;
  logic [1:0]      status_r, status_nxt;
  logic [CntW-1:0] count_r, count_nxt;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign full     = valid_v[DEPTH-1];
  assign empty    = !valid_v[0];

  always_comb begin
    cmd.push   = accept && (in_opcode == OP_PUSH) && !full;
    cmd.pop    = accept && (in_opcode == OP_POP) && !empty;
    cmd.prio   = in_new_priority;
    cmd.data   = in_new_data;
    status_nxt = status_r;
    count_nxt  = count_r;
    if (accept) begin
      status_nxt = ST_OK;
      if (in_opcode == OP_PUSH && full) begin
        status_nxt = ST_FULL_PUSH;
      end else if (in_opcode == OP_POP && empty) begin
        status_nxt = ST_EMPTY_POP;
      end
      if (cmd.push) begin
        count_nxt = count_r + 1'b1;
      end else if (cmd.pop) begin
        count_nxt = count_r - 1'b1;
      end
    end
    out_valid_nxt = accept || (out_valid_r && !out_ready);
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                    l_stay, l_valid, r_valid;
    logic signed [PrioW-1:0] l_prio, r_prio;
    logic        [DataW-1:0] l_data, r_data;

    if (i == 0) begin : g_first
      assign l_stay  = 1'b1;
      assign l_valid = 1'b0;
      assign l_prio  = '0;
      assign l_data  = '0;
    end else begin : g_mid
      assign l_stay  = stay_v[i-1];
      assign l_valid = valid_v[i-1];
      assign l_prio  = prio_a[i-1];
      assign l_data  = data_a[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign r_valid = 1'b0;
      assign r_prio  = '0;
      assign r_data  = '0;
    end else begin : g_inner
      assign r_valid = valid_v[i+1];
      assign r_prio  = prio_a[i+1];
      assign r_data  = data_a[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .left_stay  (l_stay),
      .left_valid (l_valid),
      .left_prio  (l_prio),
      .left_data  (l_data),
      .right_valid(r_valid),
      .right_prio (r_prio),
      .right_data (r_data),
      .stay       (stay_v[i]),
      .valid      (valid_v[i]),
      .prio       (prio_a[i]),
      .data       (data_a[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      status_r    <= ST_OK;
      count_r     <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      status_r    <= status_nxt;
      count_r     <= count_nxt;
    end
  end

  // The cells change only on an accepted item, which also replaces the result.
  assign out_valid        = out_valid_r;
  assign out_head_data    = valid_v[0] ? data_a[0] : '0;
  assign out_head_present = valid_v[0];
  assign out_entry_total  = TotalW'(count_r[EtW-1:0]);
  assign out_status       = status_r;

  a_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot({1'b0, valid_v} + 1'b1))
    else $error("Valid cells do not form an unbroken run from the head.");

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_v) == count_r)
    else $error("Entry count disagrees with the valid cells.");

  a_head_order: assert property (@(posedge clk) disable iff (!rst_n)
    valid_v[1] |-> (prio_a[0] >= prio_a[1]))
    else $error("Head entry is less urgent than the second entry.");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == ST_FULL_PUSH) |-> (count_r == CntW'(DEPTH)))
    else $error("Push was dropped although the queue was not full.");

endmodule
`default_nettype wire

FILE: hw/rtl/spq_cell.sv
// One cell of the sorted chain: holds one entry and moves it on push or pop.
`default_nettype none
module spq_cell (
  input  logic                            clk,
  input  logic                            rst_n,
  input  spq_pkg::spq_cmd_t               cmd,
  input  logic                            left_stay,
  input  logic                            left_valid,
  input  logic signed [spq_pkg::PrioW-1:0] left_prio,
  input  logic        [spq_pkg::DataW-1:0] left_data,
  input  logic                            right_valid,
  input  logic signed [spq_pkg::PrioW-1:0] right_prio,
  input  logic        [spq_pkg::DataW-1:0] right_data,
  output logic                            stay,
  output logic                            valid,
  output logic signed [spq_pkg::PrioW-1:0] prio,
  output logic        [spq_pkg::DataW-1:0] data
);
  import spq_pkg::*;

  logic                    valid_r, valid_nxt;
  logic signed [PrioW-1:0] prio_r, prio_nxt;
  logic        [DataW-1:0] data_r, data_nxt;
  logic                    load;

  // An entry stays put on a push when it is at least as urgent as the new one.
  assign stay = valid_r && (prio_r >= cmd.prio);

  always_comb begin
    valid_nxt = valid_r;
    prio_nxt  = prio_r;
    data_nxt  = data_r;
    load      = 1'b0;
    if (cmd.push && !stay) begin
      load = 1'b1;
      if (left_stay) begin
        valid_nxt = 1'b1;
        prio_nxt  = cmd.prio;
        data_nxt  = cmd.data;
      end else begin
        valid_nxt = left_valid;
        prio_nxt  = left_prio;
        data_nxt  = left_data;
      end
    end else if (cmd.pop) begin
      load      = 1'b1;
      valid_nxt = right_valid;
      prio_nxt  = right_prio;
      data_nxt  = right_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      prio_r <= prio_nxt;
      data_r <= data_nxt;
    end
  end

  assign valid = valid_r;
  assign prio  = prio_r;
  assign data  = data_r;

endmodule
`default_nettype wire

FILE: verif/tb_sorted_priority_queue.sv
// Self-checking testbench for the sorted priority queue: random push, pop and idle traffic.
module tb_sorted_priority_queue;
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  localparam int QDEPTH = spq_pkg::DefaultDepth;
  localparam logic [1:0] OP_NOP  = 2'd2;
  localparam logic [1:0] OP_RSVD = 2'd3;
  localparam int RANDOM_ITEMS = 1725;
  localparam int CALM_FROM = 550;
  localparam int CALM_TO = 900;

  typedef struct {
    logic        [1:0]       opcode;
    logic signed [PrioW-1:0] prio;
    logic signed [DataW-1:0] data;
    bit                      drain_first;
  } queue_op_t;

  typedef struct {
    logic signed [DataW-1:0]  head_data;
    logic                     head_present;
    logic        [TotalW-1:0] entry_total;
    logic        [1:0]        status;
  } head_report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_opcode = OP_NOP;
  logic signed [PrioW-1:0] in_new_priority = '0;
  logic signed [DataW-1:0] in_new_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [DataW-1:0] out_head_data;
  logic out_head_present;
  logic [TotalW-1:0] out_entry_total;
  logic [1:0] out_status;

  queue_op_t pending_ops[$];
  head_report_t expected_reports[$];

  logic signed [PrioW-1:0] model_prio[QDEPTH];
  logic signed [DataW-1:0] model_data[QDEPTH];
  int model_fill = 0;

  int items_sent = 0;
  int results_seen = 0;
  int failures = 0;
  int n_push = 0;
  int n_pop = 0;
  int n_full_push = 0;
  int n_empty_pop = 0;
  int peak_fill = 0;

  sorted_priority_queue #(.DEPTH(QDEPTH)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_opcode(in_opcode),
    .in_new_priority(in_new_priority),
    .in_new_data(in_new_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_head_data(out_head_data),
    .out_head_present(out_head_present),
    .out_entry_total(out_entry_total),
    .out_status(out_status)
  );

  always #6 clk = ~clk;

  task automatic queue_item(input logic [1:0] op, input logic signed [PrioW-1:0] prio,
                            input logic signed [DataW-1:0] data, input bit drain);
    queue_op_t item;
    item.opcode = op;
    item.prio = prio;
    item.data = data;
    item.drain_first = drain;
    pending_ops.push_back(item);
  endtask

  task automatic apply_queue_op(input logic [1:0] op, input logic signed [PrioW-1:0] prio,
                                input logic signed [DataW-1:0] data,
                                output head_report_t report);
    int pos;
    int k;
    report.status = ST_OK;
    if (op == OP_PUSH) begin
      if (model_fill >= QDEPTH) begin
        report.status = ST_FULL_PUSH;
        n_full_push++;
      end else begin
        pos = 0;
        while (pos < model_fill && model_prio[pos] >= prio) pos++;
        for (k = model_fill; k > pos; k--) begin
          model_prio[k] = model_prio[k-1];
          model_data[k] = model_data[k-1];
        end
        model_prio[pos] = prio;
        model_data[pos] = data;
        model_fill++;
        n_push++;
      end
    end else if (op == OP_POP) begin
      if (model_fill == 0) begin
        report.status = ST_EMPTY_POP;
        n_empty_pop++;
      end else begin
        for (k = 0; k + 1 < model_fill; k++) begin
          model_prio[k] = model_prio[k+1];
          model_data[k] = model_data[k+1];
        end
        model_fill--;
        n_pop++;
      end
    end
    if (model_fill > peak_fill) peak_fill = model_fill;
    report.head_data = (model_fill > 0) ? model_data[0] : '0;
    report.head_present = (model_fill > 0);
    report.entry_total = model_fill[TotalW-1:0];
  endtask

  // Driver: offers the next pending item once the current one has transferred.
  always @(posedge clk) begin : driver
    int sent_now;
    logic hold;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      sent_now = items_sent + ((in_valid && in_ready) ? 1 : 0);
      items_sent <= sent_now;
      if (!in_valid || in_ready) begin
        hold = 1'b0;
        if (pending_ops.size() == 0) begin
          hold = 1'b1;
        end else if (pending_ops[0].drain_first && results_seen != sent_now) begin
          hold = 1'b1;
        end else if (!(sent_now >= CALM_FROM && sent_now < CALM_TO) &&
                     $urandom_range(99) < 22) begin
          hold = 1'b1;
        end
        if (hold) begin
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_opcode <= pending_ops[0].opcode;
          in_new_priority <= pending_ops[0].prio;
          in_new_data <= pending_ops[0].data;
          pending_ops.pop_front();
        end
      end
    end
  end

  // Receiver: random back-pressure plus long hold-offs that stall the input side.
  always @(posedge clk) begin : receiver
    int stall_left;
    int next_stall_at;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left <= 0;
      next_stall_at <= 650;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (results_seen >= next_stall_at) begin
      out_ready <= 1'b0;
      stall_left <= 90;
      next_stall_at <= next_stall_at + 750;
    end else begin
      out_ready <= (results_seen >= CALM_FROM && results_seen < CALM_TO) ||
                   ($urandom_range(99) >= 22);
    end
  end

  // Monitor: predicts on each input transfer, checks each result transfer.
  always @(posedge clk) begin : monitor
    head_report_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        apply_queue_op(in_opcode, in_new_priority, in_new_data, want);
        expected_reports.push_back(want);
      end
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (expected_reports.size() == 0) begin
          $error("result transfer with no pending expectation");
          failures++;
        end else begin
          want = expected_reports.pop_front();
          if (out_head_data !== want.head_data) begin
            $error("head_data: expected %0d, got %0d", want.head_data, out_head_data);
            failures++;
          end
          if (out_head_present !== want.head_present) begin
            $error("head_present: expected %0d, got %0d", want.head_present,
                   out_head_present);
            failures++;
          end
          if (out_entry_total !== want.entry_total) begin
            $error("entry_total: expected %0d, got %0d", want.entry_total,
                   out_entry_total);
            failures++;
          end
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            failures++;
          end
        end
      end
    end
  end

  initial begin
    int n;
    int burst;
    int push_pct;
    int r;
    logic [1:0] op;
    logic signed [PrioW-1:0] prio;

    queue_item(OP_POP, 16'sh1234, 32'h0badf00d, 1'b0);
    queue_item(OP_NOP, 16'sh7fff, 32'hffffffff, 1'b0);
    queue_item(OP_RSVD, -16'sd1, 32'h00000000, 1'b0);
    queue_item(OP_PUSH, 16'sh7fff, 32'h7fffffff, 1'b0);
    queue_item(OP_PUSH, -16'sh8000, 32'h80000000, 1'b0);
    queue_item(OP_PUSH, 16'sd0, 32'h00000000, 1'b0);
    queue_item(OP_PUSH, -16'sd1, 32'hffffffff, 1'b0);
    queue_item(OP_PUSH, 16'sd0, 32'h00000001, 1'b0);
    queue_item(OP_PUSH, 16'sh7fff, 32'h00000002, 1'b0);
    queue_item(OP_PUSH, -16'sh8000, 32'h00000003, 1'b0);
    queue_item(OP_PUSH, 16'sd1, 32'h55555555, 1'b0);
    queue_item(OP_PUSH, -16'sd2, 32'haaaaaaaa, 1'b0);
    for (n = 0; n < 7; n++) begin
      queue_item(OP_PUSH, $urandom_range(6) - 3, $urandom, 1'b0);
    end
    queue_item(OP_PUSH, 16'sd5, 32'hdeadbeef, 1'b0);
    queue_item(OP_RSVD, 16'sd7, 32'h12345678, 1'b0);
    queue_item(OP_NOP, -16'sd7, 32'h87654321, 1'b0);
    for (n = 0; n < 3; n++) begin
      queue_item(OP_POP, $urandom, $urandom, 1'b0);
    end

    n = 0;
    while (n < RANDOM_ITEMS) begin
      burst = $urandom_range(40, 6);
      case ($urandom_range(2))
        0: push_pct = 85;
        1: push_pct = 50;
        default: push_pct = 15;
      endcase
      repeat (burst) begin
        r = $urandom_range(99);
        if (r < 3) op = OP_RSVD;
        else if (r < 8) op = OP_NOP;
        else if ($urandom_range(99) < push_pct) op = OP_PUSH;
        else op = OP_POP;
        case ($urandom_range(9))
          6, 7: prio = $urandom;
          8: prio = 16'sh7fff;
          9: prio = -16'sh8000;
          default: prio = $urandom_range(6) - 3;
        endcase
        queue_item(op, prio, $urandom, (n == 0) || (n == 1000));
        n++;
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk); while (pending_ops.size() != 0 || in_valid);
    do @(posedge clk); while (expected_reports.size() != 0);
    repeat (10) @(posedge clk);

    $display("Ran %0d operations: %0d pushes, %0d pops, %0d pushes dropped when full,",
             items_sent, n_push, n_pop, n_full_push);
    $display("%0d pops on an empty queue, peak fill %0d of %0d entries.",
             n_empty_pop, peak_fill, QDEPTH);
    if (failures == 0 && expected_reports.size() == 0) begin
      $display("sorted_priority_queue regression: pass");
    end else begin
      $display("sorted_priority_queue regression: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("sorted_priority_queue regression: fail");
    $finish;
  end

endmodule
